// ----- hw/rtl/query_field_extractor_defines.svh -----
// Assertion macros shared by the query field extractor modules.
`ifndef QUERY_FIELD_EXTRACTOR_DEFINES_SVH
`define QUERY_FIELD_EXTRACTOR_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define QFE_ASSERT_NOW(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

// Condition implies consequence in the next cycle.
`define QFE_ASSERT_NEXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/qfe_pkg.sv -----
// Types, constants and helper functions for the query field extractor.
package qfe_pkg;

	localparam int MAX_KEY_BYTES = 8;
	localparam int KEY_IDX_W     = $clog2(MAX_KEY_BYTES);

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [4:0] HEX_RADIX = 5'd16;

	localparam logic [1:0] REG_KEY_BYTES   = 2'd0;
	localparam logic [1:0] REG_KEY_LENGTH  = 2'd1;
	localparam logic [1:0] REG_VALUE_LIMIT = 2'd2;

	typedef enum logic [1:0] {
		PH_MATCH = 2'd0,
		PH_SKIP  = 2'd1,
		PH_VALUE = 2'd2,
		PH_DONE  = 2'd3
	} qfe_phase_t;

	typedef enum logic [1:0] {
		PEND_NONE = 2'd0,
		PEND_PCT  = 2'd1,
		PEND_CHAR = 2'd2
	} qfe_pend_t;

	typedef struct packed {
		logic [63:0] key_bytes;
		logic [3:0]  key_length;
		logic [7:0]  value_limit;
	} qfe_cfg_t;

	typedef struct packed {
		logic [7:0] value_byte;
		logic       byte_valid;
		logic       value_done;
		logic       key_found;
	} qfe_result_t;

	// One or two results caused by one input word
	typedef struct packed {
		logic        two;
		qfe_result_t r0;
		qfe_result_t r1;
	} qfe_pair_t;

	// Bit 4 set when the character is a hex digit, low nibble holds its value
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] d;
		d = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			d = {1'b1, 4'(c[3:0] + 4'd9)};
		end
		return d;
	endfunction

	function automatic logic [7:0] hex_pair(input logic [7:0] h1, input logic [7:0] h2);
		logic [4:0] d1;
		logic [4:0] d2;
		logic [7:0] v;
		d1 = hex_digit(h1);
		d2 = hex_digit(h2);
		if (!d1[4]) begin
			v = 8'd0;
		end else if (!d2[4]) begin
			v = {4'd0, d1[3:0]};
		end else begin
			v = ({4'd0, d1[3:0]} * {3'd0, HEX_RADIX}) | {4'd0, d2[3:0]};
		end
		return v;
	endfunction

endpackage

// ----- hw/rtl/query_field_extractor.sv -----
// Top level of the query field extractor: input stage, configuration and result queue.
//
// Takes one query-string character per cycle on the s_ stream while s_tready is high
// (s_tlast on the last character) and returns the URL-decoded value of the configured
// key on the m_ stream, ending each string with exactly one word that has m_tlast set.
// A character is registered on entry, decoded from that register and its results
// written to a two-entry result queue that offers them on m_; the character is held
// in the register while its results cannot enter the queue.
// Sustained rate is one character per cycle while the queue has room; a character
// that ends a value with an unfinished percent escape can yield two result words.
// Configuration registers must be written only while no string is in flight.
// No clearing pass is needed after reset.
module query_field_extractor
	import qfe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // text_byte
	input  logic        s_tlast,    // final_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,    // value_byte
	output logic [1:0]  m_tuser,    // [0] byte_valid, [1] key_found
	output logic        m_tlast,    // value_done
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	qfe_cfg_t   cfg_q;
	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       fin_s1;
	logic       advance;
	logic       full;
	logic       has_res;
	qfe_pair_t  res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_bytes   <= 64'd0;
			cfg_q.key_length  <= 4'd1;
			cfg_q.value_limit <= 8'd255;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_KEY_BYTES:   cfg_q.key_bytes   <= cfg_data;
				REG_KEY_LENGTH:  cfg_q.key_length  <= cfg_data[3:0];
				REG_VALUE_LIMIT: cfg_q.value_limit <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Hold the word while its results cannot enter the queue
	assign advance  = vld_s1 && (!has_res || !full);
	assign s_tready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			fin_s1  <= s_tlast;
		end
	end

	qfe_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.text_byte  (byte_s1),
		.final_byte (fin_s1),
		.cfg        (cfg_q),
		.res        (res),
		.has_res    (has_res)
	);

	qfe_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance && has_res),
		.push_pair (res),
		.full      (full),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// ----- hw/rtl/qfe_scan.sv -----
// Key match, value capture and URL decoding for one registered input word.
`include "query_field_extractor_defines.svh"

module qfe_scan
	import qfe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [7:0] text_byte,
	input  logic       final_byte,
	input  qfe_cfg_t   cfg,
	output qfe_pair_t  res,
	output logic       has_res
);

	qfe_phase_t ph_q, ph_n;
	qfe_pend_t  pend_q, pend_n;
	logic [3:0] pos_q, pos_n;
	logic [7:0] raw_q, raw_n;
	logic [7:0] pchar_q, pchar_n;

	logic [3:0] klen;
	logic [7:0] kc;
	logic       do_finish;
	logic [1:0] n;
	qfe_result_t r0, r1, item;

	assign klen = (cfg.key_length > 4'(MAX_KEY_BYTES)) ? 4'(MAX_KEY_BYTES) : cfg.key_length;
	assign kc   = cfg.key_bytes[8 * pos_q[KEY_IDX_W-1:0] +: 8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= PH_MATCH;
			pend_q  <= PEND_NONE;
			pos_q   <= 4'd0;
			raw_q   <= 8'd0;
			pchar_q <= 8'd0;
		end else if (advance) begin
			ph_q    <= ph_n;
			pend_q  <= pend_n;
			pos_q   <= pos_n;
			raw_q   <= raw_n;
			pchar_q <= pchar_n;
		end
	end

	always_comb begin
		ph_n      = ph_q;
		pend_n    = pend_q;
		pos_n     = pos_q;
		raw_n     = raw_q;
		pchar_n   = pchar_q;
		do_finish = 1'b0;
		n         = 2'd0;
		r0        = '0;
		r1        = '0;
		item      = '0;

		case (ph_q)
			PH_MATCH: begin
				if (text_byte == CH_AMP) begin
					pos_n = 4'd0;
				end else if (pos_q < klen) begin
					if (text_byte == kc) begin
						pos_n = 4'(pos_q + 4'd1);
					end else begin
						ph_n = PH_SKIP;
					end
				end else if (text_byte == CH_EQ) begin
					ph_n    = PH_VALUE;
					raw_n   = 8'd0;
					pend_n  = PEND_NONE;
					pchar_n = 8'd0;
					do_finish = (cfg.value_limit == 8'd0);
				end else begin
					ph_n = PH_SKIP;
				end
			end
			PH_SKIP: begin
				if (text_byte == CH_AMP) begin
					ph_n  = PH_MATCH;
					pos_n = 4'd0;
				end
			end
			PH_VALUE: begin
				if (text_byte == CH_AMP) begin
					do_finish = 1'b1;
				end else begin
					case (pend_q)
						PEND_NONE: begin
							if (text_byte == CH_PCT) begin
								pend_n = PEND_PCT;
							end else begin
								r0.value_byte = (text_byte == CH_PLUS) ? CH_SPACE : text_byte;
								r0.byte_valid = 1'b1;
								n = 2'd1;
							end
						end
						PEND_PCT: begin
							pchar_n = text_byte;
							pend_n  = PEND_CHAR;
						end
						default: begin
							r0.value_byte = hex_pair(pchar_q, text_byte);
							r0.byte_valid = 1'b1;
							n = 2'd1;
							pend_n = PEND_NONE;
						end
					endcase
					raw_n = 8'(raw_q + 8'd1);
					do_finish = (raw_n >= cfg.value_limit);
				end
			end
			default: begin
			end
		endcase

		// Reaching the end of a string mid-value closes the value as well
		if (final_byte && ph_n == PH_VALUE) begin
			do_finish = 1'b1;
		end

		if (do_finish) begin
			// Flush an incomplete escape literally
			if (pend_n != PEND_NONE) begin
				item = '{value_byte: CH_PCT, byte_valid: 1'b1, value_done: 1'b0, key_found: 1'b0};
				if (n == 2'd0) r0 = item; else r1 = item;
				n = 2'(n + 2'd1);
			end
			if (pend_n == PEND_CHAR) begin
				item = '{value_byte: pchar_n, byte_valid: 1'b1, value_done: 1'b0, key_found: 1'b0};
				if (n == 2'd0) r0 = item; else r1 = item;
				n = 2'(n + 2'd1);
			end
			pend_n = PEND_NONE;
			case (n)
				2'd0: begin
					r0 = '{value_byte: 8'd0, byte_valid: 1'b0, value_done: 1'b1, key_found: 1'b1};
					n  = 2'd1;
				end
				2'd1: begin
					r0.value_done = 1'b1;
					r0.key_found  = 1'b1;
				end
				default: begin
					r1.value_done = 1'b1;
					r1.key_found  = 1'b1;
				end
			endcase
			ph_n = PH_DONE;
		end

		if (final_byte) begin
			if (ph_n != PH_DONE) begin
				r0 = '{value_byte: 8'd0, byte_valid: 1'b0, value_done: 1'b1, key_found: 1'b0};
				n  = 2'd1;
			end
			ph_n    = PH_MATCH;
			pos_n   = 4'd0;
			raw_n   = 8'd0;
			pend_n  = PEND_NONE;
			pchar_n = 8'd0;
		end
	end

	assign res     = '{two: (n == 2'd2), r0: r0, r1: r1};
	assign has_res = (n != 2'd0);

	`QFE_ASSERT_NOW(a_pair_literal, advance && res.two, res.r0.byte_valid && res.r1.byte_valid, "two results must both carry characters")
	`QFE_ASSERT_NOW(a_found_done, advance && has_res && res.r0.key_found, res.r0.value_done, "key_found without value_done")
	`QFE_ASSERT_NOW(a_pos_bound, 1'b1, pos_q <= 4'(MAX_KEY_BYTES), "match position beyond the key")

endmodule

// ----- hw/rtl/qfe_out_buf.sv -----
// Two-deep result-pair queue that hands out results one word at a time.
`include "query_field_extractor_defines.svh"

module qfe_out_buf
	import qfe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  qfe_pair_t  push_pair,
	output logic       full,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // value_byte
	output logic [1:0] m_tuser,   // [0] byte_valid, [1] key_found
	output logic       m_tlast    // value_done
);

	qfe_pair_t   pair_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        sel_q;
	qfe_pair_t   head;
	qfe_result_t cur;
	logic        take;
	logic        pop;

	assign head     = pair_q[rd_ptr_q];
	assign cur      = sel_q ? head.r1 : head.r0;
	assign full     = (cnt_q == 2'd2);
	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = cur.value_byte;
	assign m_tuser  = {cur.key_found, cur.byte_valid};
	assign m_tlast  = cur.value_done;
	assign take     = m_tvalid && m_tready;
	assign pop      = take && (sel_q || !head.two);

	always_ff @(posedge clk) begin
		if (push) begin
			pair_q[wr_ptr_q] <= push_pair;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
			sel_q    <= 1'b0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			// advance to the second word of a pair, or drop the pair
			if (take) sel_q <= !pop;
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end

	`QFE_ASSERT_NOW(a_no_overflow, push, !full, "push into a full result queue")
	`QFE_ASSERT_NOW(a_sel_two, sel_q, m_tvalid && head.two, "second word selected on a single-result pair")
	`QFE_ASSERT_NEXT(a_second_follows, take && !pop, sel_q && m_tvalid, "second word of a pair lost")

endmodule

// ----- tb/qfe_value_checker.sv -----
`timescale 1ns / 100ps
// Checker for the query field extractor: predicts result words and compares them.
module qfe_value_checker
	import qfe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,    // text_byte
	input  logic        s_tlast,    // final_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,    // value_byte
	input  logic [1:0]  m_tuser,    // [0] byte_valid, [1] key_found
	input  logic        m_tlast,    // value_done
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output int          fail_count,
	output int          words_due
);

	logic [63:0] key_chars;
	logic [3:0]  key_len;
	logic [7:0]  raw_limit;

	qfe_phase_t  phase;
	int          matched;
	logic [7:0]  raw_taken;
	qfe_pend_t   escape;
	logic [7:0]  escape_char;

	qfe_result_t expected_words[$];
	qfe_result_t step_words[$];
	qfe_result_t want;
	int          errs;

	// -1 when the character is not a hex digit
	function automatic int hex_value(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
		if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
		if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
		return -1;
	endfunction

	task automatic emit(input logic [7:0] b, input logic v, input logic d, input logic f);
		qfe_result_t w;
		w.value_byte = b;
		w.byte_valid = v;
		w.value_done = d;
		w.key_found  = f;
		step_words.push_back(w);
	endtask

	// Flush an unfinished escape literally and mark the end of the value
	task automatic close_value();
		qfe_result_t w;
		if (escape != PEND_NONE) emit(CH_PCT, 1'b1, 1'b0, 1'b0);
		if (escape == PEND_CHAR) emit(escape_char, 1'b1, 1'b0, 1'b0);
		escape = PEND_NONE;
		if (step_words.size() > 0) begin
			w = step_words.pop_back();
			w.value_done = 1'b1;
			w.key_found  = 1'b1;
			step_words.push_back(w);
		end else begin
			emit(8'h00, 1'b0, 1'b1, 1'b1);
		end
		phase = PH_DONE;
	endtask

	task automatic predict_char(input logic [7:0] c, input logic fin);
		int klen;
		int d1;
		int d2;
		step_words.delete();
		klen = (key_len > 4'd8) ? MAX_KEY_BYTES : int'(key_len);
		case (phase)
			PH_MATCH: begin
				if (c == CH_AMP) begin
					matched = 0;
				end else if (matched < klen) begin
					if (c == key_chars[8*matched +: 8]) matched = matched + 1;
					else phase = PH_SKIP;
				end else if (c == CH_EQ) begin
					phase       = PH_VALUE;
					raw_taken   = 8'd0;
					escape      = PEND_NONE;
					escape_char = 8'd0;
					if (raw_limit == 8'd0) close_value();
				end else begin
					phase = PH_SKIP;
				end
			end
			PH_SKIP: begin
				if (c == CH_AMP) begin
					phase   = PH_MATCH;
					matched = 0;
				end
			end
			PH_VALUE: begin
				if (c == CH_AMP) begin
					close_value();
				end else begin
					case (escape)
						PEND_NONE: begin
							if (c == CH_PCT) escape = PEND_PCT;
							else emit((c == CH_PLUS) ? CH_SPACE : c, 1'b1, 1'b0, 1'b0);
						end
						PEND_PCT: begin
							escape_char = c;
							escape      = PEND_CHAR;
						end
						default: begin
							d1 = hex_value(escape_char);
							d2 = hex_value(c);
							if (d1 < 0) emit(8'h00, 1'b1, 1'b0, 1'b0);
							else if (d2 < 0) emit(8'(d1), 1'b1, 1'b0, 1'b0);
							else emit(8'(d1 * int'(HEX_RADIX) + d2), 1'b1, 1'b0, 1'b0);
							escape = PEND_NONE;
						end
					endcase
					raw_taken = raw_taken + 8'd1;
					if (raw_taken >= raw_limit) close_value();
				end
			end
			default: ;
		endcase
		if (fin) begin
			if (phase == PH_VALUE) close_value();
			else if (phase != PH_DONE) emit(8'h00, 1'b0, 1'b1, 1'b0);
			phase       = PH_MATCH;
			matched     = 0;
			raw_taken   = 8'd0;
			escape      = PEND_NONE;
			escape_char = 8'd0;
		end
		foreach (step_words[i]) expected_words.push_back(step_words[i]);
	endtask

	task automatic compare_field(input string field, input logic [7:0] exp_v,
			input logic [7:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0h, got %0h", field, exp_v, got_v);
			errs++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_chars   = 64'd0;
			key_len     = 4'd1;
			raw_limit   = 8'd255;
			phase       = PH_MATCH;
			matched     = 0;
			raw_taken   = 8'd0;
			escape      = PEND_NONE;
			escape_char = 8'd0;
			errs        = 0;
			expected_words.delete();
			fail_count <= 0;
			words_due  <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_KEY_BYTES:   key_chars = cfg_data;
					REG_KEY_LENGTH:  key_len   = cfg_data[3:0];
					REG_VALUE_LIMIT: raw_limit = cfg_data[7:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) predict_char(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				if (expected_words.size() == 0) begin
					$error("unexpected word: value_byte %0h byte_valid %0b value_done %0b key_found %0b",
						m_tdata, m_tuser[0], m_tlast, m_tuser[1]);
					errs++;
				end else begin
					want = expected_words.pop_front();
					compare_field("value_byte", want.value_byte, m_tdata);
					compare_field("byte_valid", 8'(want.byte_valid), 8'(m_tuser[0]));
					compare_field("value_done", 8'(want.value_done), 8'(m_tlast));
					compare_field("key_found", 8'(want.key_found), 8'(m_tuser[1]));
				end
			end
			fail_count <= errs;
			words_due  <= expected_words.size();
		end
	end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the query field extractor: stimulus, flow control and verdict.
module tb;
	import qfe_pkg::*;

	localparam int RESET_CYCLES   = 6;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES  = 6;
	localparam int STALL_LIMIT    = 4000;
	localparam int RANDOM_CHARS   = 950;
	localparam int PHASE_CHARS    = 110;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;

	int          fail_count;
	int          words_due;
	int          idle_cycles = 0;
	int          sent_chars = 0;
	int          rx_hold_asked = 0;
	logic        tx_gapless = 1'b0;

	logic [63:0] key_now;
	logic [3:0]  key_len_now;
	logic [7:0]  limit_now;
	logic [7:0]  query[$];

	query_field_extractor DUT (.*);
	qfe_value_checker value_check (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one
	function automatic int idle_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 45) return 0;
		if (roll < 85) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] key_char();
		case ($urandom_range(0, 9))
			0: return CH_PCT;
			1: return CH_PLUS;
			2: return 8'($urandom_range(0, 255));
			default: return 8'h61 + 8'($urandom_range(0, 3));
		endcase
	endfunction

	function automatic logic [63:0] rand_key();
		logic [63:0] k;
		for (int i = 0; i < 8; i++) k[8*i +: 8] = key_char();
		return k;
	endfunction

	function automatic logic [7:0] value_char();
		case ($urandom_range(0, 15))
			0, 1:    return CH_PCT;
			2:       return CH_PLUS;
			3, 4, 5: return 8'h30 + 8'($urandom_range(0, 9));
			6, 7:    return 8'h61 + 8'($urandom_range(0, 6));    // g is not a hex digit
			8:       return 8'h41 + 8'($urandom_range(0, 6));
			9:       return CH_EQ;
			10:      return CH_AMP;
			11:      return 8'($urandom_range(0, 255));
			default: return 8'h6B + 8'($urandom_range(0, 10));
		endcase
	endfunction

	// Build a string of segments: mostly the key and a value, some spoilt keys and noise
	task automatic make_query(input bit long_value);
		int segs;
		int kind;
		int n;
		int j;
		int klen;
		klen = (key_len_now > 4'd8) ? MAX_KEY_BYTES : int'(key_len_now);
		segs = $urandom_range(1, 4);
		for (int s = 0; s < segs; s++) begin
			if (s > 0) query.push_back(CH_AMP);
			kind = long_value && s == 0 ? 0 : $urandom_range(0, 9);
			if (kind < 7) begin
				n = (kind == 5) ? $urandom_range(0, klen) : klen;
				for (int k = 0; k < n; k++) query.push_back(key_now[8*k +: 8]);
				if (kind == 6 && n > 0) begin
					j = query.size() - 1 - $urandom_range(0, n - 1);
					query[j] = key_char();
				end
				query.push_back(CH_EQ);
				if (long_value && s == 0) n = 258;
				else if ($urandom_range(0, 7) == 0) n = $urandom_range(9, 40);
				else n = $urandom_range(0, 8);
				for (int k = 0; k < n; k++) query.push_back(value_char());
			end else if (kind > 7) begin
				n = $urandom_range(1, 6);
				for (int k = 0; k < n; k++) query.push_back(8'($urandom_range(0, 255)));
			end
		end
		if (query.size() == 0) query.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic send_char(input logic [7:0] c, input logic fin);
		int gap;
		gap = tx_gapless ? 0 : idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= fin;
		do @(posedge clk); while (!s_tready);
		sent_chars++;
	endtask

	task automatic send_query();
		tx_gapless = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < query.size(); i++) send_char(query[i], i == query.size() - 1);
		query.delete();
	endtask

	task automatic send_text(input string t);
		for (int i = 0; i < t.len(); i++) query.push_back(t[i]);
		send_query();
	endtask

	// Stop offering words and hold until every result is out and the pipe is empty
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (words_due != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_config(input logic [63:0] k, input logic [3:0] len,
			input logic [7:0] lim);
		key_now     = k;
		key_len_now = len;
		limit_now   = lim;
		for (int r = 0; r < 3; r++) begin
			cfg_valid <= 1'b1;
			case (r)
				0: begin
					cfg_index <= REG_KEY_BYTES;
					cfg_data  <= k;
				end
				1: begin
					cfg_index <= REG_KEY_LENGTH;
					cfg_data  <= 64'(len);
				end
				default: begin
					cfg_index <= REG_VALUE_LIMIT;
					cfg_data  <= 64'(lim);
				end
			endcase
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	// Receiver: random back-pressure, plus one long hold-off on request
	initial begin
		int run;
		int gap;
		int hold_served;
		hold_served = 0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold_asked != hold_served) begin
				m_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				hold_served++;
			end
			run = $urandom_range(1, 30);
			m_tready <= 1'b1;
			repeat (run) @(posedge clk);
			gap = idle_len();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int phase_no;
		int phase_start;
		int random_start;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= 8'd0;
		s_tlast   <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_KEY_BYTES;
		cfg_data  <= 64'd0;
		key_now     = 64'd0;
		key_len_now = 4'd1;
		limit_now   = 8'd255;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Out of reset the key is a single NUL character
		query.push_back(8'h00);
		send_text("=Z");
		drain();
		load_config(64'h6B, 4'd1, 8'd255);    // key "k"
		send_text("k=%4a+");
		send_text("k=%zz%3z%");
		send_text("k=%g&");
		send_text("q");
		send_text("k=");
		drain();
		load_config(64'h6B, 4'd1, 8'd0);
		send_text("k=a");
		drain();
		load_config(64'h6B, 4'd1, 8'd2);
		send_text("k=abc");
		drain();
		load_config(64'h6B, 4'd0, 8'd255);
		send_text("=v");
		drain();
		load_config(64'h26, 4'd1, 8'd255);    // key "&" can never match
		send_text("&=x");

		phase_no     = 0;
		random_start = sent_chars;
		while (sent_chars - random_start < RANDOM_CHARS) begin
			drain();
			case (phase_no)
				0: load_config(rand_key(), 4'd8, 8'd255);
				1: load_config(rand_key(), 4'd1, 8'd1);
				2: load_config(rand_key(), 4'd0, 8'($urandom_range(1, 12)));
				3: load_config({64{1'b1}}, 4'd15, 8'd0);
				4: load_config(64'd0, 4'($urandom_range(1, 8)), 8'($urandom_range(2, 12)));
				default: load_config(rand_key(),
					($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8)),
					($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 10)));
			endcase
			phase_start = sent_chars;
			// Hold the receiver off so the block fills and stalls its input
			if (phase_no == 2) rx_hold_asked++;
			if (phase_no == 0) begin
				make_query(1'b1);
				send_query();
			end
			while (sent_chars - phase_start < PHASE_CHARS) begin
				make_query(1'b0);
				send_query();
			end
			phase_no++;
		end

		drain();
		if (fail_count == 0 && words_due == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
